// ===== rtl/core/icmper_pkg.sv =====
// ----------------------------------------------------------------------------
// icmper_pkg
// Shared types and constants of the ICMP echo responder core.
// ----------------------------------------------------------------------------
package icmper_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 64;

    localparam int IPV4_MIN_HDR = 20;
    localparam int OFS_SRC      = 12;
    localparam int OFS_DST      = 16;
    localparam int ICMP_HDR_LEN = 4;

    localparam logic [7:0] ICMP_TYPE_ECHO  = 8'd8;
    localparam logic [7:0] ICMP_TYPE_REPLY = 8'd0;

    typedef enum logic [1:0] {
        S_RX,
        S_DECIDE,
        S_TX
    } t_state;

    typedef struct packed {
        logic rx_en;
        logic tx_run;
    } t_cmd;

    typedef struct packed {
        logic last_acc;
        logic reply_ok;
        logic tx_done;
    } t_sts;

endpackage

// ===== rtl/core/icmper_ctrl.sv =====
// ----------------------------------------------------------------------------
// icmper_ctrl
// Sequencer: receive a packet, judge it, then stream the reply out.
// ----------------------------------------------------------------------------
module icmper_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  icmper_pkg::t_sts i_sts,
    output icmper_pkg::t_cmd o_cmd
);
    import icmper_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RX;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RX: begin
                if (i_sts.last_acc) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.reply_ok) begin
                    n_state = S_TX;
                end else begin
                    n_state = S_RX;
                end
            end
            S_TX: begin
                if (i_sts.tx_done) begin
                    n_state = S_RX;
                end
            end
            default: begin
                n_state = S_RX;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_RX: begin
                o_cmd.rx_en = 1'b1;
            end
            S_DECIDE: begin
                o_cmd = '0;
            end
            S_TX: begin
                o_cmd.tx_run = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/icmper_dp.sv =====
// ----------------------------------------------------------------------------
// icmper_dp
// Datapath: packet memory, header capture, running checksum, reply stream.
// ----------------------------------------------------------------------------
module icmper_dp #(
    parameter int MAX_PACKET_BYTES = icmper_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  icmper_pkg::t_cmd i_cmd,
    output icmper_pkg::t_sts o_sts,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_wdata,
    input  logic             i_rx_valid,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_rx_last,
    output logic             o_rx_ready,
    output logic             o_tx_valid,
    output logic [7:0]       o_tx_byte,
    output logic             o_tx_last,
    input  logic             i_tx_ready
);
    import icmper_pkg::*;

    localparam int W_ADDR = $clog2(MAX_PACKET_BYTES);
    localparam int W_CNT  = $clog2(MAX_PACKET_BYTES + 1);
    localparam int W_CMP  = (W_CNT > 7) ? W_CNT : 7;

    function automatic logic [7:0] be_byte(input logic [31:0] w32, input logic [1:0] sel);
        logic [7:0] b;
        case (sel)
            2'd0:    b = w32[31:24];
            2'd1:    b = w32[23:16];
            2'd2:    b = w32[15:8];
            default: b = w32[7:0];
        endcase
        return b;
    endfunction

    logic [7:0] mem [MAX_PACKET_BYTES];

    logic [31:0]      r_own_ip;
    logic [W_CNT-1:0] r_count;
    logic [W_CNT-1:0] r_len;
    logic [3:0]       r_ihl;
    logic [7:0]       r_type;
    logic [31:0]      r_src;
    logic [31:0]      r_dst;
    logic [15:0]      r_acc;

    logic [W_CNT-1:0] r_addr;
    logic             r_rd_valid;
    logic [7:0]       r_rd_data;
    logic [W_ADDR-1:0] r_rd_idx;
    logic             r_rd_last;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic [15:0]      n_acc;
    logic [W_CNT-1:0] n_count;

    logic             rx_acc;
    logic             stored;
    logic [W_ADDR-1:0] wr_idx;
    logic [W_CMP-1:0] idx_c;
    logic [W_CMP-1:0] hdr_c;
    logic             ck_add;
    logic [15:0]      acc_base;
    logic [15:0]      word;
    logic [16:0]      sum17;

    logic             move;
    logic             rd_free;
    logic             issue;
    logic [W_CMP-1:0] rd_c;
    logic [W_CMP-1:0] len_c;
    logic [15:0]      ck;
    logic [7:0]       tx_sub;

    assign o_rx_ready = i_cmd.rx_en;
    assign rx_acc     = i_rx_valid && i_cmd.rx_en;
    assign stored     = r_count < W_CNT'(MAX_PACKET_BYTES);
    assign wr_idx     = r_count[W_ADDR-1:0];
    assign idx_c      = W_CMP'(r_count);
    assign hdr_c      = W_CMP'({r_ihl, 2'b00});
    assign len_c      = W_CMP'(r_len);

    assign ck_add   = stored && (idx_c > hdr_c) && (idx_c != hdr_c + W_CMP'(2))
                      && (idx_c != hdr_c + W_CMP'(3));
    assign acc_base = (r_count == '0) ? 16'd0 : r_acc;
    assign word     = r_count[0] ? {8'd0, i_rx_byte} : {i_rx_byte, 8'd0};
    assign sum17    = {1'b0, acc_base} + {1'b0, (ck_add ? word : 16'd0)};
    assign n_acc    = sum17[15:0] + {15'd0, sum17[16]};
    assign n_count  = stored ? r_count + W_CNT'(1) : r_count;

    always_ff @(posedge i_clk) begin
        if (rx_acc && stored) begin
            mem[wr_idx] <= i_rx_byte;
        end
        if (issue) begin
            r_rd_data <= mem[r_addr[W_ADDR-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_own_ip <= i_cfg_wdata;
            end
            if (rx_acc) begin
                r_count <= i_rx_last ? '0 : n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_acc) begin
            r_acc <= n_acc;
            if (i_rx_last) begin
                r_len <= n_count;
            end
            if (stored && (idx_c == '0)) begin
                r_ihl <= i_rx_byte[3:0];
            end
            if (stored && (idx_c == hdr_c)) begin
                r_type <= i_rx_byte;
            end
            if (stored && (idx_c >= W_CMP'(OFS_SRC)) && (idx_c < W_CMP'(OFS_DST))) begin
                r_src <= {r_src[23:0], i_rx_byte};
            end
            if (stored && (idx_c >= W_CMP'(OFS_DST)) && (idx_c < W_CMP'(IPV4_MIN_HDR))) begin
                r_dst <= {r_dst[23:0], i_rx_byte};
            end
        end
    end

    assign o_sts.last_acc = rx_acc && i_rx_last;
    assign o_sts.reply_ok = (len_c >= W_CMP'(IPV4_MIN_HDR)) && (hdr_c >= W_CMP'(IPV4_MIN_HDR))
                            && (hdr_c + W_CMP'(ICMP_HDR_LEN) <= len_c)
                            && (r_type == ICMP_TYPE_ECHO) && (r_dst == r_own_ip);
    assign o_sts.tx_done  = r_out_valid && i_tx_ready && r_out_last;

    assign move    = r_rd_valid && (!r_out_valid || i_tx_ready);
    assign rd_free = !r_rd_valid || move;
    assign issue   = i_cmd.tx_run && (r_addr < r_len) && rd_free;
    assign rd_c    = W_CMP'(r_rd_idx);
    assign ck      = ~r_acc;

    always_comb begin
        tx_sub = r_rd_data;
        if ((rd_c >= W_CMP'(OFS_SRC)) && (rd_c < W_CMP'(OFS_DST))) begin
            tx_sub = be_byte(r_dst, rd_c[1:0]);
        end else if ((rd_c >= W_CMP'(OFS_DST)) && (rd_c < W_CMP'(IPV4_MIN_HDR))) begin
            tx_sub = be_byte(r_src, rd_c[1:0]);
        end else if (rd_c == hdr_c) begin
            tx_sub = ICMP_TYPE_REPLY;
        end else if (rd_c == hdr_c + W_CMP'(2)) begin
            tx_sub = ck[15:8];
        end else if (rd_c == hdr_c + W_CMP'(3)) begin
            tx_sub = ck[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_sts.last_acc) begin
                r_addr <= '0;
            end else if (issue) begin
                r_addr <= r_addr + W_CNT'(1);
            end
            if (issue) begin
                r_rd_valid <= 1'b1;
            end else if (move) begin
                r_rd_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_tx_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_idx  <= r_addr[W_ADDR-1:0];
            r_rd_last <= (r_addr + W_CNT'(1)) == r_len;
        end
        if (move) begin
            r_out_byte <= tx_sub;
            r_out_last <= r_rd_last;
        end
    end

    assign o_tx_valid = r_out_valid;
    assign o_tx_byte  = r_out_byte;
    assign o_tx_last  = r_out_last;

endmodule

// ===== rtl/core/icmp_echo_responder_core.sv =====
// After the final input byte, S_DECIDE judges the packet before S_TX streams the reply.
// Throughput: one byte per cycle in, then one byte per cycle out from the packet memory
//   while i_m_axis_tready stays high.
// Input is held off after the final byte; for a reply, until its last byte is taken.
// Reset (synchronous, active low) clears control state and own_ip; the packet memory
//   is not cleared.
// ----------------------------------------------------------------------------
// icmp_echo_responder_core
// Buffers an IPv4 packet and answers an ICMP echo request addressed to own_ip.
// ----------------------------------------------------------------------------
module icmp_echo_responder_core #(
    parameter int MAX_PACKET_BYTES = icmper_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,      // own_ip
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // rx_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // tx_byte
    output logic        o_m_axis_tlast
);
    import icmper_pkg::*;

    t_cmd cmd;
    t_sts sts;

    icmper_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    icmper_dp #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx_valid  (i_s_axis_tvalid),
        .i_rx_byte   (i_s_axis_tdata),
        .i_rx_last   (i_s_axis_tlast),
        .o_rx_ready  (o_s_axis_tready),
        .o_tx_valid  (o_m_axis_tvalid),
        .o_tx_byte   (o_m_axis_tdata),
        .o_tx_last   (o_m_axis_tlast),
        .i_tx_ready  (i_m_axis_tready)
    );

`ifndef SYNTH
    a_no_rx_during_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid)
        else $error("reply byte pending while input is open");

    a_hold_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.last_acc |=> !o_s_axis_tready)
        else $error("input reopened right after final byte");

    a_rx_after_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.tx_done |=> (o_s_axis_tready && !o_m_axis_tvalid))
        else $error("input not reopened after last reply transaction");
`endif

endmodule
